@@ rtl/mbsd_pkg.sv @@
// Package: shared types, decode codes and the instruction decode function.
package mbsd_pkg;

    localparam int unsigned WordW       = 32;
    localparam int unsigned ByteW       = 8;
    localparam int unsigned QueueDepth  = 2;

    typedef logic [WordW-1:0] word_t;

    // Word transaction between the byte packer, the queue and the decoder.
    typedef struct packed {
        logic  valid;
        word_t word;
    } word_xfer_t;

    typedef enum logic [5:0] {
        MN_UNKNOWN = 6'd0,
        MN_ADD     = 6'd1,  MN_ADDU    = 6'd2,  MN_AND     = 6'd3,
        MN_DIV     = 6'd4,  MN_DIVU    = 6'd5,  MN_JALR    = 6'd6,
        MN_JR      = 6'd7,  MN_MFHI    = 6'd8,  MN_MFLO    = 6'd9,
        MN_MTHI    = 6'd10, MN_MTLO    = 6'd11, MN_MULT    = 6'd12,
        MN_MULTU   = 6'd13, MN_NOR     = 6'd14, MN_OR      = 6'd15,
        MN_SLL     = 6'd16, MN_SLLV    = 6'd17, MN_SLT     = 6'd18,
        MN_SLTU    = 6'd19, MN_SRA     = 6'd20, MN_SRAV    = 6'd21,
        MN_SRL     = 6'd22, MN_SRLV    = 6'd23, MN_SUB     = 6'd24,
        MN_SUBU    = 6'd25, MN_SYSCALL = 6'd26, MN_XOR     = 6'd27,
        MN_ADDI    = 6'd28, MN_ADDIU   = 6'd29, MN_ANDI    = 6'd30,
        MN_BEQ     = 6'd31, MN_BNE     = 6'd32, MN_LB      = 6'd33,
        MN_LBU     = 6'd34, MN_LH      = 6'd35, MN_LHU     = 6'd36,
        MN_LUI     = 6'd37, MN_LW      = 6'd38, MN_ORI     = 6'd39,
        MN_SB      = 6'd40, MN_SLTI    = 6'd41, MN_SLTIU   = 6'd42,
        MN_SH      = 6'd43, MN_SW      = 6'd44, MN_XORI    = 6'd45,
        MN_J       = 6'd46, MN_JAL     = 6'd47
    } mnemonic_t;

    typedef enum logic [3:0] {
        FMT_NONE     = 4'd0,
        FMT_RD_RS_RT = 4'd1,
        FMT_RS_RT    = 4'd2,
        FMT_RD_RS    = 4'd3,
        FMT_RS       = 4'd4,
        FMT_RD       = 4'd5,
        FMT_RD_RT_SH = 4'd6,
        FMT_RD_RT_RS = 4'd7,
        FMT_RT_RS_IM = 4'd8,
        FMT_RT_OFF_B = 4'd9,
        FMT_RT_IM    = 4'd10,
        FMT_RS_RT_IM = 4'd11,
        FMT_TARGET   = 4'd12,
        FMT_UNKNOWN  = 4'd13
    } format_t;

    // Primary opcodes (bits 31..26)
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // Function codes (bits 5..0) under the special opcode
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    typedef struct packed {
        mnemonic_t mn;
        format_t   fmt;
    } decode_t;

    function automatic decode_t decode_word(input word_t w);
        decode_t    d;
        logic [5:0] op;
        logic [5:0] fn;
        op = w[31:26];
        fn = w[5:0];
        d.mn  = MN_UNKNOWN;
        d.fmt = FMT_UNKNOWN;
        if (op == OP_SPECIAL) begin
            case (fn)
                FN_ADD:     begin d.mn = MN_ADD;     d.fmt = FMT_RD_RS_RT; end
                FN_ADDU:    begin d.mn = MN_ADDU;    d.fmt = FMT_RD_RS_RT; end
                FN_AND:     begin d.mn = MN_AND;     d.fmt = FMT_RD_RS_RT; end
                FN_DIV:     begin d.mn = MN_DIV;     d.fmt = FMT_RS_RT;    end
                FN_DIVU:    begin d.mn = MN_DIVU;    d.fmt = FMT_RS_RT;    end
                FN_JALR:    begin d.mn = MN_JALR;    d.fmt = FMT_RD_RS;    end
                FN_JR:      begin d.mn = MN_JR;      d.fmt = FMT_RS;       end
                FN_MFHI:    begin d.mn = MN_MFHI;    d.fmt = FMT_RD;       end
                FN_MFLO:    begin d.mn = MN_MFLO;    d.fmt = FMT_RD;       end
                FN_MTHI:    begin d.mn = MN_MTHI;    d.fmt = FMT_RS;       end
                FN_MTLO:    begin d.mn = MN_MTLO;    d.fmt = FMT_RS;       end
                FN_MULT:    begin d.mn = MN_MULT;    d.fmt = FMT_RS_RT;    end
                FN_MULTU:   begin d.mn = MN_MULTU;   d.fmt = FMT_RS_RT;    end
                FN_NOR:     begin d.mn = MN_NOR;     d.fmt = FMT_RD_RS_RT; end
                FN_OR:      begin d.mn = MN_OR;      d.fmt = FMT_RD_RS_RT; end
                FN_SLL:     begin d.mn = MN_SLL;     d.fmt = FMT_RD_RT_SH; end
                FN_SLLV:    begin d.mn = MN_SLLV;    d.fmt = FMT_RD_RT_RS; end
                FN_SLT:     begin d.mn = MN_SLT;     d.fmt = FMT_RD_RS_RT; end
                FN_SLTU:    begin d.mn = MN_SLTU;    d.fmt = FMT_RD_RS_RT; end
                FN_SRA:     begin d.mn = MN_SRA;     d.fmt = FMT_RD_RT_SH; end
                FN_SRAV:    begin d.mn = MN_SRAV;    d.fmt = FMT_RD_RT_RS; end
                FN_SRL:     begin d.mn = MN_SRL;     d.fmt = FMT_RD_RT_SH; end
                FN_SRLV:    begin d.mn = MN_SRLV;    d.fmt = FMT_RD_RT_RS; end
                FN_SUB:     begin d.mn = MN_SUB;     d.fmt = FMT_RD_RS_RT; end
                FN_SUBU:    begin d.mn = MN_SUBU;    d.fmt = FMT_RD_RS_RT; end
                FN_SYSCALL: begin d.mn = MN_SYSCALL; d.fmt = FMT_NONE;     end
                FN_XOR:     begin d.mn = MN_XOR;     d.fmt = FMT_RD_RS_RT; end
                default:    begin d.mn = MN_UNKNOWN; d.fmt = FMT_UNKNOWN;  end
            endcase
        end
        else begin
            case (op)
                OP_ADDI:  begin d.mn = MN_ADDI;    d.fmt = FMT_RT_RS_IM; end
                OP_ADDIU: begin d.mn = MN_ADDIU;   d.fmt = FMT_RT_RS_IM; end
                OP_ANDI:  begin d.mn = MN_ANDI;    d.fmt = FMT_RT_RS_IM; end
                OP_BEQ:   begin d.mn = MN_BEQ;     d.fmt = FMT_RS_RT_IM; end
                OP_BNE:   begin d.mn = MN_BNE;     d.fmt = FMT_RS_RT_IM; end
                OP_LB:    begin d.mn = MN_LB;      d.fmt = FMT_RT_OFF_B; end
                OP_LBU:   begin d.mn = MN_LBU;     d.fmt = FMT_RT_OFF_B; end
                OP_LH:    begin d.mn = MN_LH;      d.fmt = FMT_RT_OFF_B; end
                OP_LHU:   begin d.mn = MN_LHU;     d.fmt = FMT_RT_OFF_B; end
                OP_LUI:   begin d.mn = MN_LUI;     d.fmt = FMT_RT_IM;    end
                OP_LW:    begin d.mn = MN_LW;      d.fmt = FMT_RT_OFF_B; end
                OP_ORI:   begin d.mn = MN_ORI;     d.fmt = FMT_RT_RS_IM; end
                OP_SB:    begin d.mn = MN_SB;      d.fmt = FMT_RT_OFF_B; end
                OP_SLTI:  begin d.mn = MN_SLTI;    d.fmt = FMT_RT_RS_IM; end
                OP_SLTIU: begin d.mn = MN_SLTIU;   d.fmt = FMT_RT_RS_IM; end
                OP_SH:    begin d.mn = MN_SH;      d.fmt = FMT_RT_OFF_B; end
                OP_SW:    begin d.mn = MN_SW;      d.fmt = FMT_RT_OFF_B; end
                OP_XORI:  begin d.mn = MN_XORI;    d.fmt = FMT_RT_RS_IM; end
                OP_J:     begin d.mn = MN_J;       d.fmt = FMT_TARGET;   end
                OP_JAL:   begin d.mn = MN_JAL;     d.fmt = FMT_TARGET;   end
                default:  begin d.mn = MN_UNKNOWN; d.fmt = FMT_UNKNOWN;  end
            endcase
        end
        return d;
    endfunction

endpackage

@@ rtl/mbsd_front.sv @@
// Front end: packs bytes, MSB first, into 32-bit words for the queue.
module mbsd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mbsd_pkg::ByteW-1:0]  in_byte,
    output mbsd_pkg::word_xfer_t        push,
    input  logic                        push_ready
);
    import mbsd_pkg::*;

    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic        last_byte;
    logic        accept;

    assign last_byte = (pos_reg == 2'd3);
    // Only the closing byte needs room in the queue.
    assign in_ready  = !last_byte || push_ready;
    assign accept    = in_valid && in_ready;

    assign push.valid = in_valid && last_byte;
    assign push.word  = {partial_reg, in_byte};

    always_comb
    begin
        pos_next     = pos_reg;
        partial_next = partial_reg;
        if (accept) begin
            pos_next = pos_reg + 2'd1;
            if (last_byte) begin
                partial_next = '0;
            end
            else begin
                partial_next = {partial_reg[15:0], in_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= '0;
            partial_reg <= '0;
        end
        else begin
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
        end
    end

endmodule

@@ rtl/mbsd_queue.sv @@
// Short word queue decoupling the byte packer from the decoder.
module mbsd_queue #(
    parameter int unsigned Depth = mbsd_pkg::QueueDepth
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbsd_pkg::word_xfer_t        push,
    output logic                        push_ready,
    output mbsd_pkg::word_xfer_t        pop,
    input  logic                        pop_ready
);
    import mbsd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    word_t           mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop.valid  = (count_reg != '0);
    assign pop.word   = mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/mbsd_back.sv @@
// Back end: decodes queued words into the registered result stage.
module mbsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbsd_pkg::word_xfer_t        pop,
    output logic                        pop_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 inst_number,
    output logic [31:0]                 raw_word,
    output logic [5:0]                  mnemonic_code,
    output logic [3:0]                  format_code
);
    import mbsd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] counter_reg;
    logic [31:0] counter_next;
    logic [31:0] number_reg;
    word_t       word_reg;
    mnemonic_t   mn_reg;
    format_t     fmt_reg;
    decode_t     dec;
    logic        load;

    // Result stage reloads when empty or being drained this cycle.
    assign pop_ready = !valid_reg || out_ready;
    assign load      = pop.valid && pop_ready;
    assign dec       = decode_word(pop.word);

    always_comb
    begin
        valid_next   = valid_reg;
        counter_next = counter_reg;
        if (load) begin
            valid_next   = 1'b1;
            counter_next = counter_reg + 32'd1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg   <= 1'b0;
            counter_reg <= '0;
        end
        else begin
            valid_reg   <= valid_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            number_reg <= counter_reg;
            word_reg   <= pop.word;
            mn_reg     <= dec.mn;
            fmt_reg    <= dec.fmt;
        end
    end

    assign out_valid     = valid_reg;
    assign inst_number   = number_reg;
    assign raw_word      = word_reg;
    assign mnemonic_code = mn_reg;
    assign format_code   = fmt_reg;

endmodule

@@ rtl/mips_byte_stream_instruction_decoder.sv @@
// Top level: byte-stream MIPS-I decoder (packer, word queue, decoder).
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | in_byte
//  out     | output    | out_valid / out_ready| inst_number, raw_word, mnemonic_code,
//          |           |                      | format_code, reg_d, reg_s, reg_t,
//          |           |                      | shift_amount, immediate, jump_target
//
//  One byte transaction per cycle while in_ready is high; every fourth byte yields
//  one result transaction. A closing byte reaches out_valid through the queue, then
//  the result register that holds the decode.
//  rst_n is asynchronous: byte position, partial word, queue and counter clear to zero.
//  Downstream stalls fill the result register, then the queue; only then is a closing
//  byte held off. The first three bytes of a group are always taken.
module mips_byte_stream_instruction_decoder #(
    parameter int unsigned QueueDepth = mbsd_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        inst_number,
    output logic [31:0]        raw_word,
    output logic [5:0]         mnemonic_code,
    output logic [3:0]         format_code,
    output logic [4:0]         reg_d,
    output logic [4:0]         reg_s,
    output logic [4:0]         reg_t,
    output logic [4:0]         shift_amount,
    output logic signed [15:0] immediate,
    output logic [25:0]        jump_target
);
    import mbsd_pkg::*;

    word_xfer_t push;
    word_xfer_t pop;
    logic       push_ready;
    logic       pop_ready;

    // Front: assembles big-endian words from the byte stream.
    mbsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push       (push),
        .push_ready (push_ready)
    );

    // Queue: lets the packer and decoder stall independently.
    mbsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    // Back: opcode/funct decode, instruction count and result register.
    mbsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_ready     (pop_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .inst_number   (inst_number),
        .raw_word      (raw_word),
        .mnemonic_code (mnemonic_code),
        .format_code   (format_code)
    );

    // Bit fields are raw slices of the word, whatever the format.
    assign reg_d        = raw_word[15:11];
    assign reg_s        = raw_word[25:21];
    assign reg_t        = raw_word[20:16];
    assign shift_amount = raw_word[10:6];
    assign immediate    = raw_word[15:0];
    assign jump_target  = raw_word[25:0];

endmodule
